// ----- rtl/irvt_pkg.sv -----
// ============================================================================
// irvt_pkg: shared types and constants of the integer value remap table
// Opcodes, default table depth and the beat that travels the cell chain.
// ============================================================================
package irvt_pkg;

    localparam int IRVT_TABLE_DEPTH = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_REMAP  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One beat as it moves through the chain. For a load, data carries the
    // new value; for a remap, data carries the running match result.
    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] key;
        logic               key_null;
        logic signed [63:0] data;
        logic               data_null;
        logic               found;
        logic               has_def;
        logic               def_null;
        logic signed [63:0] def_val;
        logic               last;
        logic               ovf;
    } t_beat;

endpackage

// ----- rtl/irvt_if.sv -----
// ============================================================================
// irvt interfaces: input and result channels of the remap table
// Valid/ready channels; a beat moves when valid and ready are both high.
// ============================================================================
interface irvt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [63:0] item_key;
    logic               item_key_null;
    logic signed [63:0] new_value;
    logic               new_value_null;
    logic               dflt_en;
    logic               default_null;
    logic signed [63:0] dflt_value;
    logic               last_of_array;

    modport source (
        output valid, opcode, item_key, item_key_null, new_value, new_value_null,
               dflt_en, default_null, dflt_value, last_of_array,
        input  ready
    );
    modport sink (
        input  valid, opcode, item_key, item_key_null, new_value, new_value_null,
               dflt_en, default_null, dflt_value, last_of_array,
        output ready
    );
endinterface

interface irvt_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] result_value;
    logic               result_null;
    logic               result_last;
    logic               table_overflow;

    modport source (
        output valid, result_value, result_null, result_last, table_overflow,
        input  ready
    );
    modport sink (
        input  valid, result_value, result_null, result_last, table_overflow,
        output ready
    );
endinterface

// ----- rtl/irvt_cell.sv -----
// ============================================================================
// irvt_cell: one table entry of the remap chain
// Hold one (key, value) pair, write it from a passing load, match passing
// remaps against it and hand every beat on to the next cell.
// ============================================================================
module irvt_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_valid,
    input  irvt_pkg::t_beat  i_beat,
    input  logic [CNT_W-1:0] i_idx,
    output logic             o_valid,
    output irvt_pkg::t_beat  o_beat,
    output logic [CNT_W-1:0] o_idx
);
    import irvt_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(CELL_IDX);

    logic signed [63:0] r_key;
    logic               r_key_null;
    logic signed [63:0] r_val;
    logic               r_val_null;

    logic               r_valid;
    t_beat              r_beat;
    logic [CNT_W-1:0]   r_idx;

    t_beat              n_beat;
    logic               w_write;
    logic               w_hit;
    logic               w_key_eq;

    assign w_write  = i_adv && i_valid && (i_beat.op == OP_LOAD) && (i_idx == MY_IDX);
    assign w_key_eq = i_beat.key_null ? r_key_null
                                      : (!r_key_null && (r_key == i_beat.key));
    // idx carries the entry count for a remap: only loaded entries count
    assign w_hit    = (i_beat.op == OP_REMAP) && (MY_IDX < i_idx) && w_key_eq;

    always_comb begin
        n_beat = i_beat;
        if (w_hit) begin
            n_beat.found     = 1'b1;
            n_beat.data      = r_val;
            n_beat.data_null = r_val_null;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_key      <= i_beat.key;
            r_key_null <= i_beat.key_null;
            r_val      <= i_beat.data;
            r_val_null <= i_beat.data_null;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_beat <= n_beat;
            r_idx  <= i_idx;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;
    assign o_idx   = r_idx;

endmodule

// ----- rtl/int_value_remap_table_core.sv -----
// ============================================================================
// int_value_remap_table_core: associative integer remap with default
// Systolic chain of table cells; loads, clears and remaps flow in order.
// ============================================================================
//
//   Channel  | Dir | Handshake        | Beat contents
//   ---------+-----+------------------+-----------------------------------------
//   i_in     | in  | valid/ready      | opcode, key, new value, default, last
//   o_out    | out | valid/ready      | remapped value, null, last, overflow
//
// Flow: one beat enters per cycle unless the chain is stalled; a remap beat is
//   captured by the first cell at the edge that takes it, passes each cell in
//   turn and then the output register, which holds its result.
// Reset: clears the entry count, the overflow flag and the chain valid bits;
//   table contents need no clearing since only entries below the count match.
// Stalls: while a result waits in the output register, the whole chain and
//   the input hold; loads and clears produce no result beat.
//
module int_value_remap_table_core #(
    parameter int TABLE_DEPTH = irvt_pkg::IRVT_TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    irvt_in_if.sink      i_in,
    irvt_out_if.source   o_out
);
    import irvt_pkg::*;

    localparam int               CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL  = CNT_W'(TABLE_DEPTH);

    // Head: entry count and sticky overflow, updated as beats are taken.
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;

    // Chain taps: index 0 feeds the first cell, index TABLE_DEPTH is the tail.
    logic               w_valid [0:TABLE_DEPTH];
    t_beat              w_beat  [0:TABLE_DEPTH];
    logic [CNT_W-1:0]   w_idx   [0:TABLE_DEPTH];

    // Output register
    logic               r_out_valid;
    logic signed [63:0] r_res_value;
    logic               r_res_null;
    logic               r_res_last;
    logic               r_res_ovf;

    logic               w_adv;
    logic               w_take;
    logic               n_res_null;
    logic signed [63:0] n_res_value;
    t_beat              w_tail;

    // Advance everything whenever the output slot is free or being drained.
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv;
    assign w_take     = i_in.valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (w_take) begin
            case (i_in.opcode)
                OP_LOAD: begin
                    if (r_count < FULL) begin
                        r_count <= r_count + CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    r_count <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Build the head beat. A load carries its target slot (the current count;
    // a full table gives a slot no cell owns, so the load drops out). A remap
    // carries the count so cells beyond it stay silent. Drop unused opcodes.
    always_comb begin
        w_valid[0]          = i_in.valid && (i_in.opcode != OP_UNUSED);
        w_idx[0]            = r_count;
        w_beat[0].op        = i_in.opcode;
        w_beat[0].key       = i_in.item_key;
        w_beat[0].key_null  = i_in.item_key_null;
        w_beat[0].data      = (i_in.opcode == OP_LOAD) ? i_in.new_value : 64'sd0;
        w_beat[0].data_null = (i_in.opcode == OP_LOAD) && i_in.new_value_null;
        w_beat[0].found     = 1'b0;
        w_beat[0].has_def   = i_in.dflt_en;
        w_beat[0].def_null  = i_in.default_null;
        w_beat[0].def_val   = i_in.dflt_value;
        w_beat[0].last      = i_in.last_of_array;
        w_beat[0].ovf       = r_ovf;
    end

    // Later cells override earlier ones, so the most recent load wins.
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        irvt_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .i_idx   (w_idx[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1]),
            .o_idx   (w_idx[g+1])
        );
    end

    // Resolve at the tail: match, else default, else the element itself.
    assign w_tail = w_beat[TABLE_DEPTH];

    always_comb begin
        if (w_tail.found) begin
            n_res_null  = w_tail.data_null;
            n_res_value = w_tail.data;
        end else if (w_tail.has_def) begin
            n_res_null  = w_tail.def_null;
            n_res_value = w_tail.def_val;
        end else begin
            n_res_null  = w_tail.key_null;
            n_res_value = w_tail.key;
        end
        if (n_res_null) begin
            n_res_value = 64'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[TABLE_DEPTH] && (w_tail.op == OP_REMAP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res_value <= n_res_value;
            r_res_null  <= n_res_null;
            r_res_last  <= w_tail.last;
            r_res_ovf   <= w_tail.ovf;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_res_value;
    assign o_out.result_null    = r_res_null;
    assign o_out.result_last    = r_res_last;
    assign o_out.table_overflow = r_res_ovf;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("entry count beyond table depth");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped without reset");

    a_full_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_in.opcode == OP_LOAD) && (r_count == FULL)) |=> r_ovf)
        else $error("load into full table did not flag overflow");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (i_in.opcode == OP_CLEAR)) |=> (r_count == '0))
        else $error("clear did not empty the table");
`endif

endmodule

// ----- tb/sv/irvt_remap_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// irvt_remap_checker: result predictor and comparator for the remap table
// Watches both channels, keeps its own copy of the table, and compares every
// result beat against the oldest predicted remap.
// ============================================================================
module irvt_remap_checker #(
    parameter int DEPTH = irvt_pkg::IRVT_TABLE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    irvt_in_if   i_in,
    irvt_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_remap_count,
    output int   o_hit_count,
    output int   o_default_count,
    output int   o_drop_count
);
    import irvt_pkg::*;

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic signed [63:0] value;
        logic               is_null;
        logic               last;
        logic               ovf;
    } t_remap_result;

    logic signed [63:0] key_mem        [DEPTH];
    logic               key_null_mem   [DEPTH];
    logic signed [63:0] value_mem      [DEPTH];
    logic               value_null_mem [DEPTH];
    int                 entries;
    logic               ovf_flag;
    t_remap_result      expected_remaps [$];

    int fails    = 0;
    int remaps   = 0;
    int hits     = 0;
    int defaults = 0;
    int drops    = 0;

    function automatic t_remap_result remap_element(
        input  logic signed [63:0] elem,
        input  logic               elem_null,
        input  logic               has_def,
        input  logic               def_null,
        input  logic signed [63:0] def_val,
        input  logic               last,
        output logic               hit
    );
        t_remap_result r;
        int            i;
        hit       = 1'b0;
        r.last    = last;
        r.ovf     = ovf_flag;
        r.is_null = has_def ? def_null : elem_null;
        r.value   = has_def ? def_val : elem;
        // newest entry first, so the latest load of a key wins
        for (i = entries - 1; i >= 0 && !hit; i--) begin
            if (elem_null ? key_null_mem[i] : (!key_null_mem[i] && key_mem[i] == elem)) begin
                hit       = 1'b1;
                r.is_null = value_null_mem[i];
                r.value   = value_mem[i];
            end
        end
        if (r.is_null)
            r.value = '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            fails++;
            if (fails <= REPORT_CAP)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_remap_result want;
        logic          hit;
        if (!i_rst_n) begin
            entries  = 0;
            ovf_flag = 1'b0;
            expected_remaps.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                case (i_in.opcode)
                    OP_LOAD: begin
                        if (entries < DEPTH) begin
                            key_mem[entries]        = i_in.item_key;
                            key_null_mem[entries]   = i_in.item_key_null;
                            value_mem[entries]      = i_in.new_value;
                            value_null_mem[entries] = i_in.new_value_null;
                            entries++;
                        end else begin
                            ovf_flag = 1'b1;
                            drops++;
                        end
                    end
                    OP_CLEAR: entries = 0;
                    OP_REMAP: begin
                        want = remap_element(i_in.item_key, i_in.item_key_null,
                                             i_in.dflt_en, i_in.default_null,
                                             i_in.dflt_value, i_in.last_of_array, hit);
                        expected_remaps.push_back(want);
                        remaps++;
                        if (hit)
                            hits++;
                        else if (i_in.dflt_en)
                            defaults++;
                    end
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_remaps.size() == 0) begin
                    fails++;
                    $error("result beat with no remap outstanding: value %0d",
                           i_out.result_value);
                end else begin
                    want = expected_remaps.pop_front();
                    check_field("result_value", want.value, i_out.result_value);
                    check_field("result_null", want.is_null, i_out.result_null);
                    check_field("result_last", want.last, i_out.result_last);
                    check_field("table_overflow", want.ovf, i_out.table_overflow);
                end
            end
        end
        o_pending       <= expected_remaps.size();
        o_fail_count    <= fails;
        o_remap_count   <= remaps;
        o_hit_count     <= hits;
        o_default_count <= defaults;
        o_drop_count    <= drops;
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench: stimulus and verdict for the integer value remap table
// Loads tables, clears them and streams remap arrays through the core with
// bursty input and a stalling result sink; the checker does the comparing.
// ============================================================================
module testbench;
    import irvt_pkg::*;

    localparam int TBL_DEPTH    = IRVT_TABLE_DEPTH;
    // time scale for the waits below: the table depth plus one
    localparam int LATENCY      = TBL_DEPTH + 1;
    localparam int RANDOM_ITEMS = 1800;
    // cycles with no beat on either channel before the run is declared hung
    localparam int IDLE_LIMIT   = 40 * LATENCY;

    localparam logic signed [63:0] KEY_MAX   = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] KEY_MIN   = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [63:0] key;
        logic               key_null;
        logic signed [63:0] new_value;
        logic               new_value_null;
        logic               dflt_en;
        logic               default_null;
        logic signed [63:0] dflt_value;
        logic               last;
    } t_remap_cmd;

    typedef enum int {
        SINK_OPEN,      // always ready
        SINK_COIN,      // ready half the time
        SINK_PATTERN,   // ready follows a rotating mask
        SINK_SPARSE     // mostly stalled
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    irvt_in_if  in_ch ();
    irvt_out_if out_ch ();

    int fail_count;
    int pending;
    int remap_count;
    int hit_count;
    int default_count;
    int drop_count;

    // Mirror of the table as the stimulus sees it: fill level and the keys
    // that are live, so remaps can be aimed at real entries.
    int                 table_fill = 0;
    logic signed [63:0] known_keys [$];
    int                 sent       = 0;
    int                 burst_left = 1;
    logic               valid_held = 1'b0;

    int_value_remap_table_core #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) i_dut (
        .i_clk,
        .i_rst_n,
        .i_in  (in_ch),
        .o_out (out_ch)
    );

    irvt_remap_checker #(
        .DEPTH (TBL_DEPTH)
    ) i_checker (
        .i_clk,
        .i_rst_n,
        .i_in            (in_ch),
        .i_out           (out_ch),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_remap_count   (remap_count),
        .o_hit_count     (hit_count),
        .o_default_count (default_count),
        .o_drop_count    (drop_count)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Bias keys toward the extremes and a small pool, so that duplicate keys
    // and exact hits show up often.
    function automatic logic signed [63:0] pick_key();
        case ($urandom_range(0, 7))
            0:       return KEY_MAX;
            1:       return KEY_MIN;
            2:       return 64'sd0;
            3:       return -64'sd1;
            4:       return 64'($urandom_range(0, 15));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Fill every field with noise; callers overwrite the ones that matter.
    function automatic t_remap_cmd blank_cmd(input logic [1:0] op);
        t_remap_cmd c;
        c.op             = op;
        c.key            = {$urandom(), $urandom()};
        c.key_null       = 1'($urandom_range(0, 1));
        c.new_value      = {$urandom(), $urandom()};
        c.new_value_null = 1'($urandom_range(0, 1));
        c.dflt_en        = 1'($urandom_range(0, 1));
        c.default_null   = 1'($urandom_range(0, 1));
        c.dflt_value     = {$urandom(), $urandom()};
        c.last           = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_remap_cmd load_cmd(
        input logic signed [63:0] key, input logic key_null,
        input logic signed [63:0] value, input logic value_null
    );
        t_remap_cmd c;
        c                = blank_cmd(OP_LOAD);
        c.key            = key;
        c.key_null       = key_null;
        c.new_value      = value;
        c.new_value_null = value_null;
        return c;
    endfunction

    function automatic t_remap_cmd remap_cmd(
        input logic signed [63:0] elem, input logic elem_null,
        input logic has_def, input logic def_null,
        input logic signed [63:0] def_val, input logic last
    );
        t_remap_cmd c;
        c               = blank_cmd(OP_REMAP);
        c.key           = elem;
        c.key_null      = elem_null;
        c.dflt_en       = has_def;
        c.default_null  = def_null;
        c.dflt_value    = def_val;
        c.last          = last;
        return c;
    endfunction

    // Present one beat and hold it until the core takes it, then start a new
    // burst, usually after a gap, when its length runs out.
    task automatic send_cmd(input t_remap_cmd c);
        int gap;
        in_ch.valid          <= 1'b1;
        in_ch.opcode         <= c.op;
        in_ch.item_key       <= c.key;
        in_ch.item_key_null  <= c.key_null;
        in_ch.new_value      <= c.new_value;
        in_ch.new_value_null <= c.new_value_null;
        in_ch.dflt_en        <= c.dflt_en;
        in_ch.default_null   <= c.default_null;
        in_ch.dflt_value     <= c.dflt_value;
        in_ch.last_of_array  <= c.last;
        valid_held = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);

        case (c.op)
            OP_LOAD: begin
                // loads into a full table are dropped by the core
                if (table_fill < TBL_DEPTH) begin
                    table_fill++;
                    if (!c.key_null)
                        known_keys.push_back(c.key);
                end
            end
            OP_CLEAR: begin
                table_fill = 0;
                known_keys.delete();
            end
            default: ;
        endcase
        if (c.op != OP_UNUSED)
            sent++;

        burst_left--;
        if (burst_left <= 0) begin
            // now and then a long steady stretch with no idling at all
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                valid_held = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Drop valid and hold off until every predicted remap has come back.
    task automatic wait_drained();
        if (valid_held) begin
            in_ch.valid <= 1'b0;
            valid_held = 1'b0;
        end
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Result sink: stall on a pattern that changes every so often.
    initial begin : result_sink
        t_sink_mode mode;
        int         left;
        logic [7:0] mask;
        out_ch.ready <= 1'b0;
        mode = SINK_OPEN;
        left = 0;
        mask = 8'hff;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = t_sink_mode'($urandom_range(0, 3));
                left = $urandom_range(20, 200);
                mask = 8'($urandom()) | 8'h01;
            end
            left--;
            case (mode)
                SINK_OPEN:    out_ch.ready <= 1'b1;
                SINK_COIN:    out_ch.ready <= 1'($urandom_range(0, 1));
                SINK_PATTERN: begin
                    out_ch.ready <= mask[0];
                    mask = {mask[0], mask[7:1]};
                end
                default:      out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Watchdog: end the run when neither channel has moved a beat for too long.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("int_value_remap_table_core: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_remap_cmd         c;
        int                 n;
        int                 j;
        int                 r;
        logic               ovf_ok;
        logic               drained_mid;
        logic               elem_null;
        logic signed [63:0] elem;

        in_ch.valid          <= 1'b0;
        in_ch.opcode         <= OP_LOAD;
        in_ch.item_key       <= '0;
        in_ch.item_key_null  <= 1'b0;
        in_ch.new_value      <= '0;
        in_ch.new_value_null <= 1'b0;
        in_ch.dflt_en        <= 1'b0;
        in_ch.default_null   <= 1'b0;
        in_ch.dflt_value     <= '0;
        in_ch.last_of_array  <= 1'b0;
        i_rst_n              <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed part ----------------
        // Empty table: element passes through, a null stays null, and the
        // default (value or null) takes over when present.
        send_cmd(remap_cmd(64'sd5, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0));
        send_cmd(remap_cmd(64'sd9, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b0));
        send_cmd(remap_cmd(64'sd7, 1'b0, 1'b1, 1'b0, KEY_MIN, 1'b0));
        send_cmd(remap_cmd(64'sd7, 1'b0, 1'b1, 1'b1, KEY_MAX, 1'b1));

        // Extreme keys, a null key stored as zero, a null value and a key
        // loaded twice: the second load of -1 has to win.
        send_cmd(load_cmd(KEY_MAX, 1'b0, KEY_MIN, 1'b0));
        send_cmd(load_cmd(KEY_MIN, 1'b0, KEY_MAX, 1'b1));
        send_cmd(load_cmd(64'sd0, 1'b1, 64'sd42, 1'b0));
        send_cmd(load_cmd(-64'sd1, 1'b0, 64'sd10, 1'b0));
        send_cmd(load_cmd(-64'sd1, 1'b0, 64'sd20, 1'b0));

        // unused opcode: must leave the table untouched and give no beat
        c     = blank_cmd(OP_UNUSED);
        c.key = -64'sd1;
        send_cmd(c);

        send_cmd(remap_cmd(KEY_MAX, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0));
        // hit on a null value beats a present default
        send_cmd(remap_cmd(KEY_MIN, 1'b0, 1'b1, 1'b0, 64'sd99, 1'b0));
        // null element finds the null-key entry whatever its raw bits say
        send_cmd(remap_cmd(KEY_MAX, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b0));
        send_cmd(remap_cmd(-64'sd1, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0));
        // non-null zero must not hit the null key
        send_cmd(remap_cmd(64'sd0, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0));
        send_cmd(remap_cmd(64'sd123, 1'b0, 1'b1, 1'b0, -64'sd5, 1'b1));
        // newer null-key entry mapping to null shadows the older one
        send_cmd(load_cmd(64'sd77, 1'b1, 64'sd0, 1'b1));
        send_cmd(remap_cmd(64'sd0, 1'b1, 1'b1, 1'b0, 64'sd3, 1'b0));

        // After a clear nothing matches any more.
        send_cmd(blank_cmd(OP_CLEAR));
        send_cmd(remap_cmd(-64'sd1, 1'b0, 1'b0, 1'b0, 64'sd0, 1'b0));
        send_cmd(remap_cmd(64'sd0, 1'b1, 1'b1, 1'b0, -64'sd5, 1'b0));
        send_cmd(remap_cmd(64'sd0, 1'b1, 1'b0, 1'b0, 64'sd0, 1'b1));
        wait_drained();

        // ---------------- random part ----------------
        // Mostly clear / load run / remap array sequences; the overflow flag
        // is sticky, so filling past capacity is held back until late.
        sent        = 0;
        drained_mid = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            ovf_ok = (sent >= RANDOM_ITEMS * 3 / 5);
            if (!drained_mid && sent >= RANDOM_ITEMS / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end

            if ($urandom_range(0, 9) != 0) begin
                if ($urandom_range(0, 9) < 7 || (!ovf_ok && table_fill > TBL_DEPTH - 16))
                    send_cmd(blank_cmd(OP_CLEAR));

                if (ovf_ok && $urandom_range(0, 7) == 0)
                    n = TBL_DEPTH - table_fill + $urandom_range(1, 4);
                else if ($urandom_range(0, 9) == 0)
                    n = $urandom_range(16, TBL_DEPTH);
                else
                    n = $urandom_range(0, 12);
                if (!ovf_ok && n > TBL_DEPTH - table_fill)
                    n = TBL_DEPTH - table_fill;

                for (j = 0; j < n; j++) begin
                    c = load_cmd(pick_key(), $urandom_range(0, 9) == 0,
                                 pick_key(), $urandom_range(0, 6) == 0);
                    // reload a live key now and then to exercise last-wins
                    if (known_keys.size() > 0 && $urandom_range(0, 3) == 0)
                        c.key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    send_cmd(c);
                end

                n = $urandom_range(1, 16);
                for (j = 0; j < n; j++) begin
                    r         = $urandom_range(0, 19);
                    elem_null = (r < 3);
                    if (r >= 3 && r < 14 && known_keys.size() > 0)
                        elem = known_keys[$urandom_range(0, known_keys.size() - 1)];
                    else
                        elem = pick_key();
                    send_cmd(remap_cmd(elem, elem_null, 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 2) == 0, pick_key(), j == n - 1));
                end
            end else begin
                // noise: any opcode with any fields, broken arrays included
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++) begin
                    c = blank_cmd(2'($urandom_range(0, 3)));
                    if (!ovf_ok && c.op == OP_LOAD && table_fill >= TBL_DEPTH)
                        c.op = OP_CLEAR;
                    send_cmd(c);
                end
            end
        end

        // Let the chain empty, then give a stray beat time to show up.
        wait_drained();
        repeat (2 * LATENCY) @(posedge i_clk);

        $display("covered %0d remaps: %0d table hits, %0d defaults taken, %0d loads dropped",
                 remap_count, hit_count, default_count, drop_count);
        if (fail_count == 0 && pending == 0)
            $display("int_value_remap_table_core: match");
        else
            $display("int_value_remap_table_core: mismatch");
        $finish;
    end

endmodule
